FILE: hdl/tcp_pkg.sv
// tcp_pkg: shared types, codes and sizes for the turtle canvas plotter
// used by every module under hdl/, no dependencies of its own
`timescale 1ns / 1ps
package tcp_pkg;

	localparam int GRID_DEF    = 32;
	localparam int QUEUE_DEPTH = 4;
	localparam int MAX_ROWS    = 32;
	localparam int ROW_W       = 32;
	localparam int ROWNUM_W    = 5;

	// command opcodes as they arrive on the input channel
	localparam logic [2:0] OPC_PEN_UP   = 3'd0;
	localparam logic [2:0] OPC_PEN_DOWN = 3'd1;
	localparam logic [2:0] OPC_TURN_R   = 3'd2;
	localparam logic [2:0] OPC_TURN_L   = 3'd3;
	localparam logic [2:0] OPC_MOVE     = 3'd4;
	localparam logic [2:0] OPC_DUMP     = 3'd5;

	localparam logic [1:0] STAT_DONE   = 2'd0;
	localparam logic [1:0] STAT_OOB    = 2'd1;
	localparam logic [1:0] STAT_BAD_OP = 2'd2;
	localparam logic [1:0] STAT_ROW    = 2'd3;

	localparam logic [1:0] HEAD_RIGHT = 2'd0;
	localparam logic [1:0] HEAD_DOWN  = 2'd1;
	localparam logic [1:0] HEAD_LEFT  = 2'd2;
	localparam logic [1:0] HEAD_UP    = 2'd3;

	typedef struct packed {
		logic [2:0] opcode;
		logic [7:0] distance;
	} tcp_cmd_t;

	typedef struct packed {
		logic [1:0]          status;
		logic [ROW_W-1:0]    row_bits;
		logic [ROWNUM_W-1:0] row_number;
		logic                last;
	} tcp_res_t;

	typedef enum logic [2:0] {
		OP_PEN_UP,
		OP_PEN_DOWN,
		OP_TURN_R,
		OP_TURN_L,
		OP_MOVE,
		OP_DUMP,
		OP_BAD
	} tcp_op_t;

	typedef struct packed {
		tcp_op_t    op;
		logic [7:0] distance;
	} tcp_qent_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DRAW,
		BK_DUMP
	} tcp_bstate_t;

endpackage

FILE: hdl/tcp_ram.sv
// tcp_ram: generic single write port, single read port ram with registered read
// depends on tcp_pkg for default sizes
`timescale 1ns / 1ps
module tcp_ram import tcp_pkg::*; #(
	parameter int WIDTH = GRID_DEF,
	parameter int DEPTH = GRID_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		// read data holds while no read is issued
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: hdl/tcp_front.sv
// tcp_front: takes commands off the input channel and classifies the opcode
// depends on tcp_pkg, feeds tcp_fifo
`timescale 1ns / 1ps
module tcp_front import tcp_pkg::*; (
	input  logic      cmd_valid,
	output logic      cmd_ready,
	input  tcp_cmd_t  cmd,
	input  logic      q_full,
	output logic      q_push,
	output tcp_qent_t q_wdata
);

	tcp_op_t op;

	always_comb begin
		case (cmd.opcode)
			OPC_PEN_UP:   op = OP_PEN_UP;
			OPC_PEN_DOWN: op = OP_PEN_DOWN;
			OPC_TURN_R:   op = OP_TURN_R;
			OPC_TURN_L:   op = OP_TURN_L;
			OPC_MOVE:     op = OP_MOVE;
			OPC_DUMP:     op = OP_DUMP;
			default:      op = OP_BAD;
		endcase
	end

	assign cmd_ready        = !q_full;
	assign q_push           = cmd_valid && !q_full;
	assign q_wdata.op       = op;
	assign q_wdata.distance = cmd.distance;

endmodule

FILE: hdl/tcp_fifo.sv
// tcp_fifo: short command queue between the front and the back end
// depends on tcp_pkg for the entry type
`timescale 1ns / 1ps
module tcp_fifo import tcp_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  tcp_qent_t wdata,
	output logic      full,
	input  logic      pop,
	output logic      valid,
	output tcp_qent_t rdata
);

	localparam int AW = $clog2(DEPTH);
	localparam int CNTW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
	localparam logic [CNTW-1:0] FULL_CNT = CNTW'(DEPTH);

	tcp_qent_t       mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CNTW-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNTW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNTW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	assign full  = (cnt_q == FULL_CNT);
	assign valid = (cnt_q != '0);
	assign rdata = mem_q[rd_ptr_q];

endmodule

FILE: hdl/tcp_back.sv
// tcp_back: executes queued commands, holds turtle state and the canvas ram
// depends on tcp_pkg and tcp_ram
`timescale 1ns / 1ps
module tcp_back import tcp_pkg::*; #(
	parameter int GRID = GRID_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_valid,
	input  tcp_qent_t q_data,
	output logic      q_pop,
	output logic      res_valid,
	input  logic      res_ready,
	output tcp_res_t  res
);

	localparam int CW = $clog2(GRID);
	localparam int SW = ((CW > 8) ? CW : 8) + 1;
	localparam int NROWS = (GRID < MAX_ROWS) ? GRID : MAX_ROWS;
	localparam logic [SW-1:0] LAST_X = SW'(GRID - 1);
	localparam logic [CW-1:0] LAST_ROW = CW'(NROWS - 1);

	tcp_bstate_t     state_q, state_d;
	logic            pen_q;
	logic [1:0]      head_q;
	logic [CW-1:0]   col_q, row_q;
	logic [CW-1:0]   cur_q, cnt_q, dump_k_q;
	logic            up_q;
	logic [GRID-1:0] mask_q;
	logic [GRID-1:0] vld_q;
	logic            pend_s1;
	logic [CW-1:0]   addr_s1;
	logic [GRID-1:0] mask_s1;
	logic            out_valid_q;
	tcp_res_t        out_q;

	logic            ram_re;
	logic [CW-1:0]   ram_raddr;
	logic [GRID-1:0] ram_rdata;
	logic [GRID-1:0] ram_wdata;
	logic [GRID-1:0] dump_row;

	logic            can_emit;
	logic            emit;
	tcp_res_t        emit_res;
	logic            dump_last;

	logic [SW-1:0]   end_c_x, end_r_x;
	logic            fits;
	logic            horiz;
	logic [CW-1:0]   end_col, end_row;
	logic [CW-1:0]   lo, hi;
	logic [GRID-1:0] hmask, vmask;

	tcp_ram #(.WIDTH(GRID), .DEPTH(GRID)) u_canvas (
		.clk   (clk),
		.we    (pend_s1),
		.waddr (addr_s1),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// rows never written read as cleared
	assign ram_wdata = (vld_q[addr_s1] ? ram_rdata : '0) | mask_s1;
	assign dump_row  = vld_q[dump_k_q] ? ram_rdata : '0;
	assign dump_last = (dump_k_q == LAST_ROW);
	assign can_emit  = !out_valid_q || res_ready;

	// end point and bounds of a move
	always_comb begin
		logic [SW-1:0] dist_x, col_x, row_x;
		dist_x  = SW'(q_data.distance);
		col_x   = SW'(col_q);
		row_x   = SW'(row_q);
		end_c_x = col_x;
		end_r_x = row_x;
		case (head_q)
			HEAD_RIGHT: begin
				end_c_x = col_x + dist_x;
				fits    = (end_c_x <= LAST_X);
			end
			HEAD_DOWN: begin
				end_r_x = row_x + dist_x;
				fits    = (end_r_x <= LAST_X);
			end
			HEAD_LEFT: begin
				end_c_x = col_x - dist_x;
				fits    = (dist_x <= col_x);
			end
			default: begin
				end_r_x = row_x - dist_x;
				fits    = (dist_x <= row_x);
			end
		endcase
	end

	assign end_col = end_c_x[CW-1:0];
	assign end_row = end_r_x[CW-1:0];
	assign horiz   = !head_q[0];
	assign lo      = (head_q == HEAD_RIGHT) ? col_q : end_col;
	assign hi      = (head_q == HEAD_RIGHT) ? end_col : col_q;
	assign vmask   = GRID'(1) << col_q;

	always_comb begin
		for (int j = 0; j < GRID; j++) begin
			hmask[j] = (CW'(j) >= lo) && (CW'(j) <= hi);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (q_pop && q_data.op == OP_DUMP) begin
					state_d = BK_DUMP;
				end else if (q_pop && q_data.op == OP_MOVE && fits && pen_q) begin
					state_d = BK_DRAW;
				end
			end
			BK_DRAW: begin
				if (cnt_q == '0) begin
					state_d = BK_IDLE;
				end
			end
			BK_DUMP: begin
				if (emit && dump_last) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		q_pop     = 1'b0;
		emit      = 1'b0;
		emit_res  = '0;
		ram_re    = 1'b0;
		ram_raddr = cur_q;
		case (state_q)
			BK_IDLE: begin
				// wait for a pending row write so the next read sees it
				if (q_valid && !pend_s1) begin
					if (q_data.op == OP_DUMP) begin
						q_pop     = 1'b1;
						ram_re    = 1'b1;
						ram_raddr = '0;
					end else if (can_emit) begin
						q_pop         = 1'b1;
						emit          = 1'b1;
						emit_res.last = 1'b1;
						if (q_data.op == OP_MOVE && !fits) begin
							emit_res.status = STAT_OOB;
						end else if (q_data.op == OP_BAD) begin
							emit_res.status = STAT_BAD_OP;
						end else begin
							emit_res.status = STAT_DONE;
						end
					end
				end
			end
			BK_DRAW: begin
				ram_re    = 1'b1;
				ram_raddr = cur_q;
			end
			BK_DUMP: begin
				if (can_emit) begin
					emit                = 1'b1;
					emit_res.status     = STAT_ROW;
					emit_res.row_bits   = ROW_W'(dump_row);
					emit_res.row_number = ROWNUM_W'(dump_k_q);
					emit_res.last       = dump_last;
					if (!dump_last) begin
						ram_re    = 1'b1;
						ram_raddr = dump_k_q + CW'(1);
					end
				end
			end
			default: begin
				q_pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			pen_q       <= 1'b0;
			head_q      <= HEAD_RIGHT;
			col_q       <= '0;
			row_q       <= '0;
			vld_q       <= '0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_s1 <= (state_q == BK_DRAW);
			if (pend_s1) begin
				vld_q[addr_s1] <= 1'b1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
			if (q_pop) begin
				case (q_data.op)
					OP_PEN_UP:   pen_q  <= 1'b0;
					OP_PEN_DOWN: pen_q  <= 1'b1;
					OP_TURN_R:   head_q <= head_q + 2'd1;
					OP_TURN_L:   head_q <= head_q + 2'd3;
					OP_MOVE: begin
						if (fits) begin
							col_q <= end_col;
							row_q <= end_row;
						end
					end
					default: pen_q <= pen_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= cur_q;
		mask_s1 <= mask_q;
		if (emit) begin
			out_q <= emit_res;
		end
		if (q_pop) begin
			cur_q    <= row_q;
			cnt_q    <= horiz ? '0 : q_data.distance[CW-1:0];
			up_q     <= (head_q == HEAD_UP);
			mask_q   <= horiz ? hmask : vmask;
			dump_k_q <= '0;
		end else if (state_q == BK_DRAW) begin
			cur_q <= up_q ? cur_q - CW'(1) : cur_q + CW'(1);
			cnt_q <= cnt_q - CW'(1);
		end else if (emit && !dump_last) begin
			dump_k_q <= dump_k_q + CW'(1);
		end
	end

	assign res_valid = out_valid_q;
	assign res       = out_q;

endmodule

FILE: hdl/turtle_canvas_plotter.sv
// turtle_canvas_plotter: turtle plotter over a GRID x GRID bit canvas
// channels: cmd (opcode, distance) in, res (status, row_bits, row_number, last) out,
// both valid/ready; a transaction happens when valid and ready are high at a clock edge.
// a command enters a short queue the cycle it is accepted, so cmd_ready only drops
// when that queue is full, independent of the result side.
// every command except dump returns one result with last set; it passes through the queue
// into the result register when the back end is idle and the result side is not stalled.
// a pen-down move in bounds occupies the canvas ram before the next command starts,
// reading then writing one row per cycle when vertical and a single row when horizontal.
// a dump returns min(GRID,32) rows, one per cycle from the canvas ram read port while the
// result side is not stalled, the final row carrying last; every other command but a
// pen-down draw completes with its pop.
// a stalled res_ready holds the result register and, through it, the back end; the
// queue keeps accepting commands until it fills.
// reset (arst_n low) clears pen, heading, position and per-row valid bits, so the
// canvas reads as cleared at once with no clearing pass.
// depends on tcp_pkg, tcp_front, tcp_fifo, tcp_back, tcp_ram
`timescale 1ns / 1ps
module turtle_canvas_plotter import tcp_pkg::*; #(
	parameter int GRID   = GRID_DEF,
	parameter int QDEPTH = QUEUE_DEPTH
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cmd_valid,
	output logic     cmd_ready,
	input  tcp_cmd_t cmd,
	output logic     res_valid,
	input  logic     res_ready,
	output tcp_res_t res
);

	localparam int NROWS = (GRID < MAX_ROWS) ? GRID : MAX_ROWS;

	logic      q_full, q_push, q_pop, q_valid;
	tcp_qent_t q_wdata, q_data;

	tcp_front u_front (
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_wdata   (q_wdata)
	);

	tcp_fifo #(.DEPTH(QDEPTH)) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.valid  (q_valid),
		.rdata  (q_data)
	);

	tcp_back #(.GRID(GRID)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_data    (q_data),
		.q_pop     (q_pop),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("back end popped an empty queue");

	a_accept_queued: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> q_valid)
		else $error("accepted command missing from queue");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.status != STAT_ROW) |-> res.last)
		else $error("non-dump result without last");

	a_dump_end: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.status == STAT_ROW) && res.last
			|-> res.row_number == ROWNUM_W'(NROWS - 1))
		else $error("dump ended on the wrong row");

endmodule
